@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define GEFA_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gefa check failed");

// Checked on every clock edge, reset included.
`define GEFA_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
        else $error("gefa check failed during reset");

`endif

@@ hw/rtl/gefa_pkg.sv @@
// Shared types and constants for the gyro/encoder angle fusion block.
package gefa_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_RATE_STEP = 2'd0;
    localparam logic [1:0] REG_SMOOTHING = 2'd1;
    localparam logic [1:0] REG_CORR_GAIN = 2'd2;

    localparam logic [31:0] RATE_STEP_RST = 32'd97734361;
    localparam logic [15:0] SMOOTHING_RST = 16'd410;
    localparam logic [15:0] CORR_GAIN_RST = 16'd412;

    typedef struct packed {
        logic [31:0] rate_step;
        logic [15:0] smoothing;
        logic [15:0] corr_gain;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_RATE,
        S_ERR,
        S_LPADD,
        S_CDIFF,
        S_CMUL,
        S_CADD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_RATE,
        MUL_DIFF_SMOOTH,
        MUL_DIFF_WEIGHT
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_ANGLE,
        ACC_LOWPASS
    } t_acc_sel;

    typedef enum logic [1:0] {
        DIFF_NONE,
        DIFF_ERR,
        DIFF_CORR
    } t_diff_sel;

    typedef struct packed {
        logic      capture;
        logic      seed;
        t_diff_sel diff_sel;
        t_mul_sel  mul_sel;
        t_acc_sel  acc_sel;
        logic      load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic seeded;
        logic enc_ok;
        logic rate_ok;
    } t_dp_status;

endpackage

@@ hw/rtl/gyro_encoder_angle_fusion_top.sv @@
// Top level of the gyro/encoder complementary angle filter.
// Before seeding an item can only seed; after it, a valid rate is integrated and,
//   with a valid encoder, low-pass and angle are updated. A stalled output holds.
// One item at a time; one shared 33x33 multiplier is used up to three times per
//   item, each product registered before its add.
// Reset (i_rst_n low, synchronous): angle, low-pass and seeded flag clear,
//   registers take their defaults, no result is pending.
module gyro_encoder_angle_fusion_top
    import gefa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // input item
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [31:0]    i_encoder_angle,
    input  logic                  i_encoder_valid,
    input  logic signed [15:0]    i_rate,
    input  logic                  i_rate_valid,
    // result item
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_fused_angle,
    output logic                  o_ready_res
);

    t_cfg       cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Gains and the rate step; the user writes them only while no item is in flight (not enforced here).
    gefa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer: seed, or integrate rate -> track encoder low-pass -> pull
    // fused angle toward the low-pass, then hand the result to the output
    // register. Input is taken only in idle.
    gefa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Binary-angle arithmetic: all sums wrap mod 2^32, products are rounded
    // half up at bit 16.
    gefa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_encoder_angle (i_encoder_angle),
        .i_encoder_valid (i_encoder_valid),
        .i_rate          (i_rate),
        .i_rate_valid    (i_rate_valid),
        .o_fused_angle   (o_fused_angle),
        .o_ready_res     (o_ready_res)
    );

endmodule

@@ hw/rtl/gefa_regs.sv @@
// APB-style configuration registers.
module gefa_regs
    import gefa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_step <= RATE_STEP_RST;
            r_cfg.smoothing <= SMOOTHING_RST;
            r_cfg.corr_gain <= CORR_GAIN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RATE_STEP: r_cfg.rate_step <= pwdata;
                REG_SMOOTHING: r_cfg.smoothing <= pwdata[15:0];
                REG_CORR_GAIN: r_cfg.corr_gain <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RATE_STEP: prdata = r_cfg.rate_step;
            REG_SMOOTHING: prdata = {16'd0, r_cfg.smoothing};
            REG_CORR_GAIN: prdata = {16'd0, r_cfg.corr_gain};
            default:       prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/gefa_dp.sv @@
// Fusion datapath: sample capture, shared multiplier, angle and low-pass state.
module gefa_dp
    import gefa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic signed [31:0] i_encoder_angle,
    input  logic               i_encoder_valid,
    input  logic signed [15:0] i_rate,
    input  logic               i_rate_valid,
    output logic signed [31:0] o_fused_angle,
    output logic               o_ready_res
);

    // captured item
    logic [31:0] r_enc;
    logic        r_enc_ok;
    logic [15:0] r_rate;
    logic        r_rate_ok;

    // filter state
    logic [31:0] r_angle;
    logic [31:0] r_lowpass;
    logic        r_seeded;

    logic [31:0] r_diff;
    logic [32:0] r_prod;      // product bits [47:15]

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [31:0]        scaled;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_RATE: begin
                mul_a = {{17{r_rate[15]}}, r_rate};
                mul_b = {1'b0, i_cfg.rate_step};
            end
            MUL_DIFF_SMOOTH: begin
                mul_a = {r_diff[31], r_diff};
                mul_b = {17'd0, i_cfg.smoothing};
            end
            MUL_DIFF_WEIGHT: begin
                mul_a = {r_diff[31], r_diff};
                mul_b = {17'd0, i_cfg.corr_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round half up: bits [47:16] plus bit 15
    assign scaled = r_prod[32:1] + {31'd0, r_prod[0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_enc     <= i_encoder_angle;
            r_enc_ok  <= i_encoder_valid;
            r_rate    <= i_rate;
            r_rate_ok <= i_rate_valid;
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= mul_p[47:15];
        end
        case (i_cmd.diff_sel)
            DIFF_ERR:  r_diff <= r_enc - r_lowpass;
            DIFF_CORR: r_diff <= r_lowpass - r_angle;
            default: ;
        endcase
        if (i_cmd.load_out) begin
            o_fused_angle <= r_angle;
            o_ready_res   <= r_seeded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle   <= '0;
            r_lowpass <= '0;
            r_seeded  <= 1'b0;
        end else if (i_cmd.seed) begin
            r_angle   <= r_enc;
            r_lowpass <= r_enc;
            r_seeded  <= 1'b1;
        end else begin
            case (i_cmd.acc_sel)
                ACC_ANGLE:   r_angle   <= r_angle + scaled;
                ACC_LOWPASS: r_lowpass <= r_lowpass + scaled;
                default: ;
            endcase
        end
    end

    assign o_status.seeded  = r_seeded;
    assign o_status.enc_ok  = r_enc_ok;
    assign o_status.rate_ok = r_rate_ok;

endmodule

@@ hw/rtl/gefa_ctrl.sv @@
// Sequencing state machine and output handshake.
module gefa_ctrl
    import gefa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = i_status.seeded ? S_RATE : S_SEED;
            S_SEED:  n_state = S_DONE;
            S_RATE:  n_state = S_ERR;
            S_ERR:   n_state = i_status.enc_ok ? S_LPADD : S_DONE;
            S_LPADD: n_state = S_CDIFF;
            S_CDIFF: n_state = S_CMUL;
            S_CMUL:  n_state = S_CADD;
            S_CADD:  n_state = S_DONE;
            S_DONE:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.diff_sel = DIFF_NONE;
        o_cmd.mul_sel  = MUL_NONE;
        o_cmd.acc_sel  = ACC_NONE;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_SEED: o_cmd.seed = i_status.enc_ok;
            S_RATE: begin
                o_cmd.mul_sel  = MUL_RATE;
                o_cmd.diff_sel = DIFF_ERR;
            end
            S_ERR: begin
                o_cmd.acc_sel = i_status.rate_ok ? ACC_ANGLE : ACC_NONE;
                o_cmd.mul_sel = MUL_DIFF_SMOOTH;
            end
            S_LPADD: o_cmd.acc_sel  = ACC_LOWPASS;
            S_CDIFF: o_cmd.diff_sel = DIFF_CORR;
            S_CMUL:  o_cmd.mul_sel  = MUL_DIFF_WEIGHT;
            S_CADD:  o_cmd.acc_sel  = ACC_ANGLE;
            S_DONE:  o_cmd.load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/gefa_checker.sv @@
// Port-level checks for the fusion top level, bound into it.
`include "assert_macros.svh"

module gefa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_fused_angle,
    input logic               o_ready_res
);

    // a pending result is not dropped
    `GEFA_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> o_out_valid)
    // one item at a time: ready drops right after an accept
    `GEFA_ASSERT(a_one_item, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // an unseeded result always reports a zero angle
    `GEFA_ASSERT(a_unseeded_zero, (o_out_valid && !o_ready_res) |-> (o_fused_angle == 32'sd0))
    // reset leaves no result pending
    `GEFA_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid)

endmodule

bind gyro_encoder_angle_fusion_top gefa_checker u_checker (.*);

@@ tb/gyro_encoder_angle_fusion_top_tb.sv @@
// Testbench for the gyro/encoder angle fusion top: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module gyro_encoder_angle_fusion_top_tb;
    import gefa_pkg::*;

    // Register slot 3 has no register behind it; writes there must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 158;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_SHOWN   = 10;

    // One input item as the block sees it.
    typedef struct packed {
        logic [31:0]        enc;
        logic               enc_ok;
        logic signed [15:0] rate;
        logic               rate_ok;
    } t_sample;

    // One result item.
    typedef struct packed {
        logic [31:0] angle;
        logic        ready;
    } t_fused;

    // Directed row: the expectation is only typed in where it is obvious.
    typedef struct {
        t_sample     s;
        logic        typed;
        t_fused      want;
    } t_dir_row;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [31:0]    i_encoder_angle;
    logic                  i_encoder_valid;
    logic signed [15:0]    i_rate;
    logic                  i_rate_valid;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [31:0]    o_fused_angle;
    logic                  o_ready_res;

    gyro_encoder_angle_fusion_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_encoder_angle (i_encoder_angle),
        .i_encoder_valid (i_encoder_valid),
        .i_rate          (i_rate),
        .i_rate_valid    (i_rate_valid),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_fused_angle   (o_fused_angle),
        .o_ready_res     (o_ready_res)
    );

    // 4 ns period
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state and its copy of the registers
    // ------------------------------------------------------------------
    logic [31:0] angle_est;
    logic [31:0] enc_lp;
    logic        is_seeded;
    logic [31:0] step_cfg;
    logic [15:0] smooth_cfg;
    logic [15:0] gain_cfg;

    t_fused fused_q[$];       // expected fused results, oldest first

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        out_hold;
    event        hold_go;

    int errors;
    int n_items;
    int n_results;
    int n_settings;

    // a * b / 2^16, round half up, modulo 2^32; a is a signed angle, b an unsigned gain
    function automatic logic [31:0] round_q16(logic [31:0] a, logic [31:0] b);
        logic [65:0] sa;
        logic [65:0] sb;
        logic [65:0] prod;
        sa   = {{34{a[31]}}, a};
        sb   = {34'd0, b};
        prod = sa * sb + 66'h8000;
        return prod[47:16];
    endfunction

    // Advance the filter by one sample and return the result it produces.
    function automatic t_fused fuse_sample(t_sample s);
        logic [31:0] rate_ext;
        logic [31:0] diff;
        t_fused      r;
        if (!is_seeded) begin
            // first valid encoder seeds both angles; the rate is not integrated
            if (s.enc_ok) begin
                angle_est = s.enc;
                enc_lp    = s.enc;
                is_seeded = 1'b1;
            end
        end else begin
            if (s.rate_ok) begin
                rate_ext  = {{16{s.rate[15]}}, s.rate};
                angle_est = angle_est + round_q16(rate_ext, step_cfg);
            end
            if (s.enc_ok) begin
                // shortest difference falls out of the wrap; a half turn reads as -180
                diff      = s.enc - enc_lp;
                enc_lp    = enc_lp + round_q16(diff, {16'd0, smooth_cfg});
                diff      = enc_lp - angle_est;
                angle_est = angle_est + round_q16(diff, {16'd0, gain_cfg});
            end
        end
        r.angle = angle_est;
        r.ready = is_seeded;
        return r;
    endfunction

    function automatic logic [31:0] reg_value(logic [1:0] idx);
        case (idx)
            REG_RATE_STEP: return step_cfg;
            REG_SMOOTHING: return {16'd0, smooth_cfg};
            REG_CORR_GAIN: return {16'd0, gain_cfg};
            default:       return 32'd0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);       // pready is tied high: written at this edge
        case (idx)
            REG_RATE_STEP: step_cfg   = data;
            REG_SMOOTHING: smooth_cfg = data[15:0];
            REG_CORR_GAIN: gain_cfg   = data[15:0];
            default: ;          // no register in this slot
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_readback(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== reg_value(idx))
            report_mismatch("register readback", reg_value(idx), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Block is idle here: every expected result has come.
    task automatic load_gains(input logic [31:0] step, input logic [15:0] smooth,
                              input logic [15:0] gain, input logic poke_unused);
        logic [15:0] junk;
        junk = 16'($urandom);
        cfg_write(REG_RATE_STEP, step);
        cfg_write(REG_SMOOTHING, {junk, smooth});
        cfg_write(REG_CORR_GAIN, {16'hFFFF, gain});
        if (poke_unused)
            cfg_write(REG_UNUSED, $urandom);
        cfg_readback(REG_RATE_STEP);
        cfg_readback(REG_SMOOTHING);
        cfg_readback(REG_CORR_GAIN);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic offer_sample(input t_sample s, input logic typed, input t_fused want);
        t_fused pred;
        // per-cycle idle chance; valid is only lowered while nothing is offered
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_encoder_angle <= s.enc;
        i_encoder_valid <= s.enc_ok;
        i_rate          <= s.rate;
        i_rate_valid    <= s.rate_ok;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pred = fuse_sample(s);
        fused_q.push_back(typed ? want : pred);
        n_items++;
    endtask

    // Stop offering and wait for every expected result.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (fused_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly encoder readings near the tracked angle, some half turns, some noise.
    function automatic t_sample rand_sample();
        t_sample     s;
        int unsigned pick;
        logic [31:0] r;
        r    = $urandom;
        pick = $urandom_range(99);
        if (pick < 55)
            s.enc = enc_lp + {{20{r[11]}}, r[11:0]};
        else if (pick < 65)
            s.enc = (enc_lp ^ 32'h8000_0000) + {{30{r[1]}}, r[1:0]};
        else
            s.enc = $urandom;
        s.enc_ok  = ($urandom_range(99) < 75);
        s.rate_ok = ($urandom_range(99) < 85);
        pick = $urandom_range(99);
        if (pick < 60)
            s.rate = {{8{r[23]}}, r[23:16]};
        else if (pick < 68)
            s.rate = 16'sh7FFF;
        else if (pick < 76)
            s.rate = 16'sh8000;
        else
            s.rate = 16'($urandom);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        out_hold = 1'b0;
        forever begin
            @hold_go;
            out_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            out_hold <= 1'b0;
        end
    end

    initial begin
        t_fused want;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                n_results++;
                if (fused_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("%t unexpected result: angle %h ready %b", $realtime,
                                 o_fused_angle, o_ready_res);
                end else begin
                    want = fused_q.pop_front();
                    if (o_fused_angle !== want.angle)
                        report_mismatch("fused_angle", want.angle, o_fused_angle);
                    if (o_ready_res !== want.ready)
                        report_mismatch("ready_res", {31'd0, want.ready}, {31'd0, o_ready_res});
                end
            end
            i_out_ready <= out_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial begin
        #2_000_000;
        $display("gyro_encoder_angle_fusion_top_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    t_dir_row dir_tab [14];

    initial begin
        int          w;
        int unsigned mode;
        t_sample     s;
        t_fused      none;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_encoder_angle = '0;
        i_encoder_valid = 1'b0;
        i_rate          = '0;
        i_rate_valid    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        errors          = 0;
        n_items         = 0;
        n_results       = 0;
        n_settings      = 0;
        none            = '0;

        angle_est  = '0;
        enc_lp     = '0;
        is_seeded  = 1'b0;
        step_cfg   = RATE_STEP_RST;
        smooth_cfg = SMOOTHING_RST;
        gain_cfg   = CORR_GAIN_RST;

        // Directed rows at the reset gains. Before seeding the output is zero;
        // the seed copies the encoder and ignores the rate.
        dir_tab = '{
            // unseeded, extremes on every field, no valid encoder
            '{'{32'h7FFF_FFFF, 1'b0, 16'sh7FFF, 1'b1}, 1'b1, '{32'h0, 1'b0}},
            '{'{32'h8000_0000, 1'b0, 16'sh8000, 1'b1}, 1'b1, '{32'h0, 1'b0}},
            '{'{32'h0000_0000, 1'b0, 16'sh0000, 1'b0}, 1'b1, '{32'h0, 1'b0}},
            // seed with a big rate that must not be integrated
            '{'{32'h4000_0000, 1'b1, 16'sh7FFF, 1'b1}, 1'b1, '{32'h4000_0000, 1'b1}},
            // neither input usable: angle holds
            '{'{32'h1234_5678, 1'b0, 16'sh8000, 1'b0}, 1'b1, '{32'h4000_0000, 1'b1}},
            // rate only, both extremes
            '{'{32'h0000_0000, 1'b0, 16'sh7FFF, 1'b1}, 1'b0, none},
            '{'{32'hFFFF_FFFF, 1'b0, 16'sh8000, 1'b1}, 1'b0, none},
            // half-turn away from the low-pass with invalid rate
            '{'{32'hC000_0000, 1'b1, 16'sh7FFF, 1'b0}, 1'b0, none},
            '{'{32'h7FFF_FFFF, 1'b1, 16'sh7FFF, 1'b1}, 1'b0, none},
            '{'{32'h8000_0000, 1'b1, 16'sh8000, 1'b1}, 1'b0, none},
            '{'{32'h0000_0000, 1'b1, 16'sh0000, 1'b1}, 1'b0, none},
            '{'{32'hFFFF_FFFF, 1'b1, 16'shFFFF, 1'b1}, 1'b0, none},
            '{'{32'h0000_0001, 1'b1, 16'sh0001, 1'b0}, 1'b0, none},
            '{'{32'h5555_AAAA, 1'b1, 16'shAAAA, 1'b1}, 1'b0, none}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k])
            offer_sample(dir_tab[k].s, dir_tab[k].typed, dir_tab[k].want);
        drain_results();

        // Random phases; each starts idle with a fresh register setting.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_gains(RATE_STEP_RST, SMOOTHING_RST, CORR_GAIN_RST, 1'b0);
                1: load_gains(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                2: load_gains(32'h0, 16'h0, 16'h0, 1'b0);
                default: begin
                    if ($urandom_range(1))
                        load_gains($urandom_range(0, 32'h0800_0000),
                                   16'($urandom_range(0, 4096)),
                                   16'($urandom_range(0, 4096)), (p == 3));
                    else
                        load_gains($urandom, 16'($urandom_range(65535)),
                                   16'($urandom_range(65535)), (p == 3));
                end
            endcase

            // idle mix: none, sender 52%, receiver 52%, both 30%
            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 52 : (mode == 3) ? 30 : 0;
            recv_stall_pct = (mode == 2) ? 52 : (mode == 3) ? 30 : 0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while items keep coming: input must back up
                if (p == 4 && n == 20)
                    -> hold_go;
                // sender pauses mid-phase until everything is back
                if (p == 6 && n == 80)
                    drain_results();
                s = rand_sample();
                offer_sample(s, 1'b0, none);
            end
            drain_results();
        end

        // Let any stray result show up, then count what never came.
        i_in_valid <= 1'b0;
        for (w = 0; w < 5000 && fused_q.size() != 0; w++)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        errors += fused_q.size();

        $display("run covered %0d samples and %0d results over %0d gain settings,",
                 n_items, n_results, n_settings);
        $display("including zero and full-scale gains, half turns, stalls and a long hold-off");
        if (errors == 0) begin
            $display("gyro_encoder_angle_fusion_top_tb OK");
        end else begin
            $display("gyro_encoder_angle_fusion_top_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gefa_pkg.sv
hw/rtl/gefa_regs.sv
hw/rtl/gefa_dp.sv
hw/rtl/gefa_ctrl.sv
hw/rtl/gyro_encoder_angle_fusion_top.sv
hw/rtl/gefa_checker.sv
tb/gyro_encoder_angle_fusion_top_tb.sv
